### design/ospfhc_pkg.sv
`default_nettype none
package ospfhc_pkg;

  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned COUNT_BITS   = 17;
  localparam int unsigned RESULT_BITS  = 127;
  localparam int unsigned TDATA_OUT_W  = 128;
  localparam logic [23:0] LLS_MASK_RESET = 24'h000200;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_VERSION  = 4'd2,
    ST_LENGTH   = 4'd3,
    ST_TYPE     = 4'd4,
    ST_AUTHTYPE = 4'd5,
    ST_DIGEST   = 4'd6,
    ST_EXCESS   = 4'd7,
    ST_RESERVED = 4'd8,
    ST_LLS      = 4'd9,
    ST_TRAILER  = 4'd10
  } status_e;

  typedef logic [HEADER_BYTES-1:0][7:0] hdr_t;

  // One packed result beat, first field in the highest bits.
  typedef struct packed {
    logic        trailer_seen;
    logic        lls_seen;
    logic        checksum_good;
    logic [7:0]  instance_res;
    logic [15:0] auth_kind;
    logic [15:0] declared_length;
    logic [31:0] area;
    logic [31:0] sender_router;
    logic [7:0]  packet_kind;
    logic [7:0]  ospf_version;
    logic [3:0]  status;
  } result_t;

endpackage
`default_nettype wire

### design/ospf_header_check_stream_core.sv
`default_nettype none
// OSPF v2/v3 header checker. The packet enters as one byte per beat on the
// slave stream, tlast on its final byte, and one result beat leaves on the
// master stream for each packet, in the cycle after the final byte is taken.
// A byte is taken in every cycle: all per-byte work (header capture, the v2
// ones'-complement sum, v3 LLS and trailer tracking) is a single add and a
// few compares ahead of the state registers, and the result register doubles
// as the output stage, so the input stalls only while a result waits unread.
// The result reports the first failed check as a status code together with
// the captured header fields; checksum_good covers only v2 packets. The LLS
// option mask may be rewritten between packets through cfg_we_i.
module ospf_header_check_stream_core
  import ospfhc_pkg::*;
#(
  parameter int unsigned CountBits = ospfhc_pkg::COUNT_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [23:0]            cfg_wdata_i,   // lls_option_mask
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,  // octet
  input  wire logic                   s_axis_tlast,  // last_octet
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [3:0] status, [11:4] ospf_version, [19:12] packet_kind,
  // [51:20] sender_router, [83:52] area, [99:84] declared_length,
  // [115:100] auth_kind, [123:116] instance_res, [124] checksum_good,
  // [125] lls_seen, [126] trailer_seen, [127] zero
  output      logic [TDATA_OUT_W-1:0] m_axis_tdata
);

  // Wide enough for byte counts and for Length plus four times a word count.
  localparam int unsigned SW = ((CountBits > 19) ? CountBits : 19) + 1;
  localparam int unsigned HIW = $clog2(HEADER_BYTES);

  logic [23:0]          mask_q;
  logic [CountBits-1:0] cnt_q, cnt_d;
  hdr_t                 hdr_q, hdr_d, hdr_n;
  logic [15:0]          sum_q, sum_d, sum_n;
  logic [7:0]           pend_q, pend_d, pend_n;
  logic [15:0]          wc_q, wc_d, wc_n;
  logic [31:0]          trl_q, trl_d, trl_n;
  logic                 ovf_q, ovf_d, ovf_n;
  logic                 out_valid_q;
  result_t              res_q, res_d;

  logic accept;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Options field of hello or database description payloads.
  function automatic logic lls_flag(input hdr_t h, input logic [SW-1:0] len,
                                    input logic [23:0] mask);
    logic [23:0] opts;
    opts = '0;
    if (h[1] == 8'd1 && len >= SW'(24)) opts = {h[21], h[22], h[23]};
    else if (h[1] == 8'd2 && len >= SW'(20)) opts = {h[17], h[18], h[19]};
    return (opts & mask) != 24'd0;
  endfunction

  logic [SW-1:0] p, len_cur, len_ofs, ts, tpos, size, len_r, suf, lls_words;
  logic          lls_now;
  hdr_t          hb;
  logic [7:0]    b, v;

  always_comb begin
    b       = s_axis_tdata;
    p       = SW'(cnt_q);
    len_cur = (cnt_q >= CountBits'(4)) ? SW'({hdr_q[2], hdr_q[3]}) : '0;
    hdr_n   = hdr_q;
    sum_n   = sum_q;
    pend_n  = pend_q;
    wc_n    = wc_q;
    trl_n   = trl_q;
    ovf_n   = ovf_q;
    cnt_d   = cnt_q;
    len_ofs = p - len_cur;
    ts      = '0;
    tpos    = '0;
    lls_now = 1'b0;
    v       = '0;
    if (cnt_q == '1) begin
      ovf_n = 1'b1;
    end else begin
      cnt_d = cnt_q + CountBits'(1);
      if (p < SW'(HEADER_BYTES)) hdr_n[cnt_q[HIW-1:0]] = b;
      if (p < SW'(4) || p < len_cur) begin
        v = (p >= SW'(16) && p < SW'(24)) ? 8'd0 : b;
        if (!p[0]) pend_n = v;
        else sum_n = oc_add(sum_q, {pend_q, v});
      end
      if (p >= SW'(16) && p >= len_cur) begin
        if (len_ofs == SW'(2)) wc_n = {b, wc_q[7:0]};
        else if (len_ofs == SW'(3)) wc_n = {wc_q[15:8], b};
        lls_now = lls_flag(hdr_n, len_cur, mask_q);
        ts      = len_cur + (lls_now ? SW'({wc_n, 2'b00}) : '0);
        tpos    = p - ts;
        if ((!lls_now || len_ofs >= SW'(4)) && p >= ts && tpos < SW'(4)) begin
          case (tpos[1:0])
            2'd0:    trl_n[31:24] = b;
            2'd1:    trl_n[23:16] = b;
            2'd2:    trl_n[15:8]  = b;
            default: trl_n[7:0]   = b;
          endcase
        end
      end
    end
  end

  // Result of a packet whose final byte is taken in this cycle.
  status_e       st;
  logic          ck, lls_ok, tr_ok, lls_f;
  logic [15:0]   auth, sum_f;
  always_comb begin
    size = SW'(cnt_d);
    for (int i = 0; i < HEADER_BYTES; i++) begin
      hb[i] = (SW'(i) < size) ? hdr_n[i] : 8'd0;
    end
    len_r     = SW'({hb[2], hb[3]});
    suf       = size - len_r;
    lls_words = SW'({wc_n, 2'b00});
    lls_f     = lls_flag(hb, len_r, mask_q);
    auth      = '0;
    st        = ST_OK;
    ck        = 1'b0;
    lls_ok    = 1'b0;
    tr_ok     = 1'b0;
    if (size < SW'(16)) begin
      st = ST_SHORT;
    end else if (hb[0] != 8'd2 && hb[0] != 8'd3) begin
      st = ST_VERSION;
    end else if (ovf_n || len_r < ((hb[0] == 8'd2) ? SW'(24) : SW'(16)) || len_r > size) begin
      st = ST_LENGTH;
    end else if (hb[1] < 8'd1 || hb[1] > 8'd5) begin
      st = ST_TYPE;
    end else if (hb[0] == 8'd2) begin
      auth = {hb[14], hb[15]};
      if (auth > 16'd2) st = ST_AUTHTYPE;
      else if (auth == 16'd2) begin
        if (hb[19] == 8'd0 || size != len_r + SW'(hb[19])) st = ST_DIGEST;
      end else if (size != len_r) st = ST_EXCESS;
    end else if (hb[15] != 8'd0) begin
      st = ST_RESERVED;
    end else if (size != len_r) begin
      if (lls_f) begin
        lls_ok = 1'b1;
        if (suf < SW'(4) || wc_n == 16'd0 || lls_words > suf) st = ST_LLS;
        else suf = suf - lls_words;
      end
      if (st == ST_OK) begin
        if (suf <= SW'(16) || trl_n[31:16] != 16'd1 || SW'(trl_n[15:0]) != suf)
          st = ST_TRAILER;
        else tr_ok = 1'b1;
      end
    end
    sum_f = len_r[0] ? oc_add(sum_n, {pend_n, 8'd0}) : sum_n;
    if (st == ST_OK && hb[0] == 8'd2) begin
      ck = (auth == 16'd2) ? ({hb[12], hb[13]} == 16'd0) : (sum_f == 16'hffff);
    end
    if (st != ST_OK) begin
      lls_ok = 1'b0;
      tr_ok  = 1'b0;
    end
    res_d.status          = st;
    res_d.ospf_version    = hb[0];
    res_d.packet_kind     = hb[1];
    res_d.sender_router   = {hb[4], hb[5], hb[6], hb[7]};
    res_d.area            = {hb[8], hb[9], hb[10], hb[11]};
    res_d.declared_length = len_r[15:0];
    res_d.auth_kind       = (hb[0] == 8'd2) ? {hb[14], hb[15]} : 16'd0;
    res_d.instance_res    = (hb[0] == 8'd3) ? hb[14] : 8'd0;
    res_d.checksum_good   = ck;
    res_d.lls_seen        = lls_ok;
    res_d.trailer_seen    = tr_ok;
  end

  // A final byte returns every per-packet register but the header capture to its starting value.
  always_comb begin
    hdr_d  = hdr_n;
    if (s_axis_tlast) begin
      sum_d  = '0;
      pend_d = '0;
      wc_d   = '0;
      trl_d  = '0;
      ovf_d  = 1'b0;
    end else begin
      sum_d  = sum_n;
      pend_d = pend_n;
      wc_d   = wc_n;
      trl_d  = trl_n;
      ovf_d  = ovf_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= LLS_MASK_RESET;
      cnt_q       <= '0;
      sum_q       <= '0;
      pend_q      <= '0;
      wc_q        <= '0;
      trl_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) mask_q <= cfg_wdata_i;
      if (accept) begin
        cnt_q  <= s_axis_tlast ? '0 : cnt_d;
        sum_q  <= sum_d;
        pend_q <= pend_d;
        wc_q   <= wc_d;
        trl_q  <= trl_d;
        ovf_q  <= ovf_d;
      end
      if (accept && s_axis_tlast) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) hdr_q <= hdr_d;
    if (accept && s_axis_tlast) res_q <= res_d;
  end

endmodule
`default_nettype wire

### design/ospfhc_checker.sv
`default_nettype none
module ospfhc_checker
  import ospfhc_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   s_axis_tlast,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [TDATA_OUT_W-1:0] m_axis_tdata
);

  // A held result beat keeps its data.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // With no result waiting the input never stalls.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A new result follows only a final input byte.
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("result without final byte");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd10)
    else $error("status out of range");

  // Flags are only reported on a clean packet.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3:0] != 4'd0 |-> m_axis_tdata[126:124] == 3'd0)
    else $error("flags set on failed packet");

endmodule

bind ospf_header_check_stream_core ospfhc_checker u_ospfhc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
